// ----- sv/msivrc_pkg.sv -----
// Package for the message-signalled interrupt register controller.
// Holds the register map, the action and access-select codes and the subfunction layout.
// No dependencies; used by the top level and its checker.
`default_nettype none

package msivrc_pkg;

  // field widths fixed by the bus and event format
  localparam int ActionW = 2;
  localparam int OffsetW = 12;
  localparam int DataW   = 32;
  localparam int FuncW   = 3;
  localparam int SubW    = 5;

  // number of implemented functions (1..8) and low data words (52..64)
  localparam int FuncCount    = 8;
  localparam int LowDataWords = 52;
  localparam int FuncSlots    = 2 ** FuncW;
  localparam int TblIdxW      = $clog2(LowDataWords);

  // register map, byte offsets
  localparam logic [OffsetW-1:0] MaskBase  = 12'h04C;
  localparam logic [OffsetW-1:0] DataBase  = 12'h08C;
  localparam logic [OffsetW-1:0] AddrBase  = 12'h0AC;
  localparam logic [OffsetW-1:0] TableBase = 12'h100;
  localparam logic [OffsetW-1:0] RegSpan   = OffsetW'(FuncCount * 4);

  // highest legal subfunction number
  localparam logic [SubW-1:0] SubLimit = 5'd30;

  // first table word and subfunction count of each function
  localparam logic [5:0] TblFirst [FuncSlots] = '{
    6'd0, 6'd4, 6'd8, 6'd12, 6'd16, 6'd40, 6'd44, 6'd48
  };
  localparam logic [5:0] TblCount [FuncSlots] = '{
    6'd4, 6'd4, 6'd4, 6'd4, 6'd24, 6'd2, 6'd2, 6'd4
  };

  // item actions
  typedef enum logic [ActionW-1:0] {
    ActRead    = 2'd0,
    ActWrite   = 2'd1,
    ActTrigger = 2'd2
  } action_e;

  // which store a register access hits
  typedef enum logic [2:0] {
    SelNone  = 3'd0,
    SelMask  = 3'd1,
    SelData  = 3'd2,
    SelAddr  = 3'd3,
    SelTable = 3'd4
  } acc_sel_e;

endpackage

`default_nettype wire

// ----- sv/msi_vector_register_controller_top.sv -----
// Top level of the message-signalled interrupt register controller.
// Per-function registers, the low data word table and the result register.
// Depends on msivrc_pkg.
//
// Usage:
//   One input channel (in_valid_i / in_ready_o) carries beats that are a
//   register read, a register write or an interrupt trigger event. One
//   output channel (out_valid_o / out_ready_i) returns exactly one result
//   beat for every input beat, in order.
//   Each accepted beat passes through the input stage, where the stores are
//   read and written, and then through the result register.
//   Throughput: one beat per cycle while the receiver keeps taking results;
//   the single read port of the table memory and of each per-function
//   register set serves one beat a cycle.
//   Reset clears all per-function registers, marks every table word as
//   zero through its valid bit and empties both stages.
//   When the receiver stalls, the result register holds its beat, the
//   input stage holds the next one and in_ready_o drops once both are full.
//   Offsets that match no register read zero and ignore writes.
`default_nettype none

module msi_vector_register_controller_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [msivrc_pkg::ActionW-1:0]   action_i,
  input  wire logic [msivrc_pkg::OffsetW-1:0]   offset_i,
  input  wire logic [msivrc_pkg::DataW-1:0]     write_value_i,
  input  wire logic [msivrc_pkg::FuncW-1:0]     func_i,
  input  wire logic [msivrc_pkg::SubW-1:0]      sub_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [msivrc_pkg::DataW-1:0]          read_data_o,
  output logic                                  msi_valid_o,
  output logic [msivrc_pkg::DataW-1:0]          msi_address_o,
  output logic [msivrc_pkg::DataW-1:0]          msi_data_o,
  output logic                                  trigger_error_o
);

  localparam int DataW   = msivrc_pkg::DataW;
  localparam int OffsetW = msivrc_pkg::OffsetW;
  localparam int FuncW   = msivrc_pkg::FuncW;
  localparam int SubW    = msivrc_pkg::SubW;
  localparam int TblIdxW = msivrc_pkg::TblIdxW;
  localparam int Slots   = msivrc_pkg::FuncSlots;
  localparam int Words   = msivrc_pkg::LowDataWords;

  // stores
  logic [DataW-1:0]   mask_q [Slots];
  logic [DataW-1:0]   base_q [Slots];
  logic [DataW-1:0]   addr_q [Slots];
  logic [DataW-1:0]   tbl_mem [Words];
  logic [Words-1:0]   tbl_vld_q;

  // handshake
  logic               in_acc;
  logic               s1_valid_q;
  logic               s2_load;

  // offset decode
  logic [OffsetW-1:0] mask_off;
  logic [OffsetW-1:0] data_off;
  logic [OffsetW-1:0] addr_off;
  logic [OffsetW-1:0] tbl_off;
  logic               hit_mask;
  logic               hit_data;
  logic               hit_addr;
  logic               hit_tbl;
  msivrc_pkg::acc_sel_e acc_sel;
  logic [FuncW-1:0]   acc_f;
  logic [FuncW-1:0]   f_rd;
  logic [6:0]         trig_sum;
  logic               trig_in_tbl;
  logic [TblIdxW-1:0] tbl_raddr;
  logic [TblIdxW-1:0] tbl_waddr;
  logic               is_write;

  // input stage
  logic [msivrc_pkg::ActionW-1:0] s1_act_q;
  msivrc_pkg::acc_sel_e           s1_sel_q;
  logic [FuncW-1:0]   s1_func_q;
  logic [SubW-1:0]    s1_sub_q;
  logic [DataW-1:0]   s1_mask_q;
  logic [DataW-1:0]   s1_base_q;
  logic [DataW-1:0]   s1_addr_q;
  logic [DataW-1:0]   s1_word_q;
  logic               s1_word_vld_q;

  // result logic
  logic [DataW-1:0]   lo_word;
  logic [DataW-1:0]   read_data_d;
  logic               msi_valid_d;
  logic [DataW-1:0]   msi_address_d;
  logic [DataW-1:0]   msi_data_d;
  logic               trigger_error_d;

  // result register
  logic               out_valid_q;
  logic [DataW-1:0]   read_data_q;
  logic               msi_valid_q;
  logic [DataW-1:0]   msi_address_q;
  logic [DataW-1:0]   msi_data_q;
  logic               trigger_error_q;

  // pipeline flow control
  assign s2_load    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_acc     = in_valid_i && in_ready_o;

  // register map decode
  assign mask_off = offset_i - msivrc_pkg::MaskBase;
  assign data_off = offset_i - msivrc_pkg::DataBase;
  assign addr_off = offset_i - msivrc_pkg::AddrBase;
  assign tbl_off  = offset_i - msivrc_pkg::TableBase;

  assign hit_mask = (offset_i >= msivrc_pkg::MaskBase) && (mask_off < msivrc_pkg::RegSpan)
                    && (offset_i[1:0] == 2'b00);
  assign hit_data = (offset_i >= msivrc_pkg::DataBase) && (data_off < msivrc_pkg::RegSpan)
                    && (offset_i[1:0] == 2'b00);
  assign hit_addr = (offset_i >= msivrc_pkg::AddrBase) && (addr_off < msivrc_pkg::RegSpan)
                    && (offset_i[1:0] == 2'b00);
  assign hit_tbl  = (offset_i >= msivrc_pkg::TableBase)
                    && (tbl_off[OffsetW-1:2] < (OffsetW-2)'(Words));

  always_comb begin
    acc_sel = msivrc_pkg::SelNone;
    acc_f   = '0;
    if (hit_mask) begin
      acc_sel = msivrc_pkg::SelMask;
      acc_f   = mask_off[FuncW+1:2];
    end else if (hit_data) begin
      acc_sel = msivrc_pkg::SelData;
      acc_f   = data_off[FuncW+1:2];
    end else if (hit_addr) begin
      acc_sel = msivrc_pkg::SelAddr;
      acc_f   = addr_off[FuncW+1:2];
    end else if (hit_tbl) begin
      acc_sel = msivrc_pkg::SelTable;
    end
  end

  // one read address for the per-function stores: the trigger's function or the decoded one
  assign f_rd = (action_i == msivrc_pkg::ActTrigger) ? func_i : acc_f;

  // table word of the triggering subfunction
  assign trig_sum    = {1'b0, msivrc_pkg::TblFirst[func_i]} + 7'(sub_i);
  assign trig_in_tbl = ({1'b0, sub_i} < msivrc_pkg::TblCount[func_i])
                       && (trig_sum < 7'(Words));

  always_comb begin
    tbl_raddr = '0;
    if (action_i == msivrc_pkg::ActRead && acc_sel == msivrc_pkg::SelTable) begin
      tbl_raddr = tbl_off[TblIdxW+1:2];
    end else if (action_i == msivrc_pkg::ActTrigger && trig_in_tbl) begin
      tbl_raddr = trig_sum[TblIdxW-1:0];
    end
  end

  assign tbl_waddr = tbl_off[TblIdxW+1:2];
  assign is_write  = in_acc && (action_i == msivrc_pkg::ActWrite);

  // per-function registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        mask_q[i] <= '0;
        base_q[i] <= '0;
        addr_q[i] <= '0;
      end
    end else if (is_write) begin
      case (acc_sel)
        msivrc_pkg::SelMask: mask_q[acc_f] <= write_value_i;
        msivrc_pkg::SelData: base_q[acc_f] <= write_value_i;
        msivrc_pkg::SelAddr: addr_q[acc_f] <= write_value_i;
        default: ;
      endcase
    end
  end

  // low data word table, registered read
  always_ff @(posedge clk_i) begin
    if (is_write && acc_sel == msivrc_pkg::SelTable) begin
      tbl_mem[tbl_waddr] <= write_value_i;
    end
    if (in_acc) begin
      s1_word_q <= tbl_mem[tbl_raddr];
    end
  end

  // table words read as zero until written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q     <= '0;
      s1_word_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_word_vld_q <= tbl_vld_q[tbl_raddr];
      if (is_write && acc_sel == msivrc_pkg::SelTable) begin
        tbl_vld_q[tbl_waddr] <= 1'b1;
      end
    end
  end

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // input stage payload and per-function read data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_act_q  <= action_i;
      s1_sel_q  <= acc_sel;
      s1_func_q <= func_i;
      s1_sub_q  <= sub_i;
      s1_mask_q <= mask_q[f_rd];
      s1_base_q <= base_q[f_rd];
      s1_addr_q <= addr_q[f_rd];
    end
  end

  // result of the beat in the input stage
  assign lo_word = s1_word_vld_q ? s1_word_q : '0;

  always_comb begin
    read_data_d     = '0;
    msi_valid_d     = 1'b0;
    msi_address_d   = '0;
    msi_data_d      = '0;
    trigger_error_d = 1'b0;
    case (s1_act_q)
      msivrc_pkg::ActRead: begin
        case (s1_sel_q)
          msivrc_pkg::SelMask:  read_data_d = s1_mask_q;
          msivrc_pkg::SelData:  read_data_d = s1_base_q;
          msivrc_pkg::SelAddr:  read_data_d = s1_addr_q;
          msivrc_pkg::SelTable: read_data_d = lo_word;
          default:              read_data_d = '0;
        endcase
      end
      msivrc_pkg::ActTrigger: begin
        if (s1_sub_q > msivrc_pkg::SubLimit) begin
          trigger_error_d = 1'b1;
        end else if (32'(s1_func_q) < 32'(msivrc_pkg::FuncCount)) begin
          if (s1_mask_q[s1_sub_q]) begin
            if ({1'b0, s1_sub_q} >= msivrc_pkg::TblCount[s1_func_q]) begin
              trigger_error_d = 1'b1;
            end else begin
              msi_valid_d   = 1'b1;
              msi_address_d = s1_addr_q;
              msi_data_d    = s1_base_q | lo_word;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_q) begin
      read_data_q     <= read_data_d;
      msi_valid_q     <= msi_valid_d;
      msi_address_q   <= msi_address_d;
      msi_data_q      <= msi_data_d;
      trigger_error_q <= trigger_error_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = read_data_q;
  assign msi_valid_o     = msi_valid_q;
  assign msi_address_o   = msi_address_q;
  assign msi_data_o      = msi_data_q;
  assign trigger_error_o = trigger_error_q;

endmodule

`default_nettype wire

// ----- sv/msivrc_chk.sv -----
// Port checker for the message-signalled interrupt register controller.
// Watches the top level's ports only; attached by the bind at the end of this file.
// Depends on msivrc_pkg and msi_vector_register_controller_top.
`default_nettype none

module msivrc_chk (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [msivrc_pkg::DataW-1:0]   read_data_o,
  input wire logic                           msi_valid_o,
  input wire logic [msivrc_pkg::DataW-1:0]   msi_address_o,
  input wire logic [msivrc_pkg::DataW-1:0]   msi_data_o,
  input wire logic                           trigger_error_o
);

  // a stalled result beat holds
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(read_data_o)
        && $stable(msi_valid_o) && $stable(msi_address_o) && $stable(msi_data_o)
        && $stable(trigger_error_o));
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result beat changed under stall");

  // a message and an error never come together
  property p_msi_xor_err;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> !(msi_valid_o && trigger_error_o);
  endproperty
  a_msi_xor_err: assert property (p_msi_xor_err) else $error("message issued with error");

  // read data only on beats that are not trigger results
  property p_read_quiet;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && read_data_o != '0) |-> (!msi_valid_o && !trigger_error_o);
  endproperty
  a_read_quiet: assert property (p_read_quiet) else $error("read data on trigger beat");

  // message fields are zero when no message goes out
  property p_msi_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !msi_valid_o) |-> (msi_address_o == '0 && msi_data_o == '0);
  endproperty
  a_msi_zero: assert property (p_msi_zero) else $error("message fields set without message");

  // an accepted beat with an empty result side shows up once it has passed the input stage
  property p_latency;
    @(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_o && !out_valid_o) |=> ##1 out_valid_o;
  endproperty
  a_latency: assert property (p_latency) else $error("result beat missing");

endmodule

bind msi_vector_register_controller_top msivrc_chk u_msivrc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .read_data_o     (read_data_o),
  .msi_valid_o     (msi_valid_o),
  .msi_address_o   (msi_address_o),
  .msi_data_o      (msi_data_o),
  .trigger_error_o (trigger_error_o)
);

`default_nettype wire

// ----- tb/tb_msi_vector_register_controller_top.sv -----
`timescale 1ns / 100ps
// Testbench for the message-signalled interrupt register controller top level.
// Drives register reads, writes and trigger beats, predicts every result beat and
// checks it field by field; depends on msivrc_pkg and msi_vector_register_controller_top.

module tb_msi_vector_register_controller_top;
  import msivrc_pkg::*;

  // action code that the block must ignore
  localparam logic [ActionW-1:0] ActSpare = 2'd3;

  localparam int StallLimit = 2000;
  localparam int LongHold   = 150;
  localparam int TailCycles = 8;
  localparam int PrintCap   = 40;
  localparam int RandChunk  = 300;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [OffsetW-1:0] offset;
    logic [DataW-1:0]   write_value;
    logic [FuncW-1:0]   func;
    logic [SubW-1:0]    sub;
  } bus_beat_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             msi_valid;
    logic [DataW-1:0] msi_address;
    logic [DataW-1:0] msi_data;
    logic             trigger_error;
  } msi_reply_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [ActionW-1:0] action_i      = '0;
  logic [OffsetW-1:0] offset_i      = '0;
  logic [DataW-1:0]   write_value_i = '0;
  logic [FuncW-1:0]   func_i        = '0;
  logic [SubW-1:0]    sub_i         = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [DataW-1:0]   read_data_o;
  logic               msi_valid_o;
  logic [DataW-1:0]   msi_address_o;
  logic [DataW-1:0]   msi_data_o;
  logic               trigger_error_o;

  msi_vector_register_controller_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .offset_i       (offset_i),
    .write_value_i  (write_value_i),
    .func_i         (func_i),
    .sub_i          (sub_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .msi_valid_o    (msi_valid_o),
    .msi_address_o  (msi_address_o),
    .msi_data_o     (msi_data_o),
    .trigger_error_o(trigger_error_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the block's stores
  logic [DataW-1:0] mask_reg [FuncSlots]    = '{default: '0};
  logic [DataW-1:0] base_reg [FuncSlots]    = '{default: '0};
  logic [DataW-1:0] addr_reg [FuncSlots]    = '{default: '0};
  logic [DataW-1:0] low_word [LowDataWords] = '{default: '0};

  bus_beat_t  bus_event_q [$];
  msi_reply_t reply_q [$];
  bus_beat_t  tx_beat;
  msi_reply_t got, want;

  logic beat_taken = 1'b0;
  bit   tx_idle    = 1'b1;
  bit   rx_idle    = 1'b1;
  int   gap_left   = 0;
  int   stall_left = 0;
  int   hold_left  = 0;
  int   hold_ask   = 0;
  int   hold_served = 0;
  int   idle_cycles = 0;
  int   mismatches = 0;
  int   beats_in   = 0;
  int   results_out = 0;
  int   n_triggers = 0;
  int   n_msgs     = 0;
  int   n_errs     = 0;

  // map a byte offset onto a store and an index within it
  function automatic void decode_offset(input logic [OffsetW-1:0] off,
                                        output acc_sel_e sel, output int idx);
    int o;
    int f;
    o   = int'(off);
    sel = SelNone;
    idx = 0;
    for (f = 0; f < FuncCount; f++) begin
      if (o == int'(MaskBase) + 4 * f) begin
        sel = SelMask;
        idx = f;
      end
      if (o == int'(DataBase) + 4 * f) begin
        sel = SelData;
        idx = f;
      end
      if (o == int'(AddrBase) + 4 * f) begin
        sel = SelAddr;
        idx = f;
      end
    end
    if (sel == SelNone && o >= int'(TableBase) &&
        ((o - int'(TableBase)) >> 2) < LowDataWords) begin
      sel = SelTable;
      idx = (o - int'(TableBase)) >> 2;
    end
  endfunction

  // result of one beat, updating the shadow stores on writes
  function automatic msi_reply_t msi_response_of(input bus_beat_t b);
    msi_reply_t r;
    acc_sel_e   sel;
    int         idx;
    int         w;
    r = '0;
    case (b.action)
      ActRead: begin
        decode_offset(b.offset, sel, idx);
        case (sel)
          SelMask:  r.read_data = mask_reg[idx];
          SelData:  r.read_data = base_reg[idx];
          SelAddr:  r.read_data = addr_reg[idx];
          SelTable: r.read_data = low_word[idx];
          default:  r.read_data = '0;
        endcase
      end
      ActWrite: begin
        decode_offset(b.offset, sel, idx);
        case (sel)
          SelMask:  mask_reg[idx] = b.write_value;
          SelData:  base_reg[idx] = b.write_value;
          SelAddr:  addr_reg[idx] = b.write_value;
          SelTable: low_word[idx] = b.write_value;
          default:  ;
        endcase
      end
      ActTrigger: begin
        if (b.sub > SubLimit) begin
          r.trigger_error = 1'b1;
        end else if (int'(b.func) < FuncCount) begin
          if (mask_reg[b.func][b.sub]) begin
            if (b.sub >= TblCount[b.func]) begin
              r.trigger_error = 1'b1;
            end else begin
              w = int'(TblFirst[b.func]) + int'(b.sub);
              r.msi_valid   = 1'b1;
              r.msi_address = addr_reg[b.func];
              r.msi_data    = base_reg[b.func] | ((w < LowDataWords) ? low_word[w] : '0);
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offset of some implemented register, table offsets with random low bits
  function automatic logic [OffsetW-1:0] reg_offset();
    int f;
    f = $urandom_range(0, FuncCount - 1);
    case ($urandom_range(0, 3))
      0:       return OffsetW'(int'(MaskBase) + 4 * f);
      1:       return OffsetW'(int'(DataBase) + 4 * f);
      2:       return OffsetW'(int'(AddrBase) + 4 * f);
      default: return OffsetW'(int'(TableBase) + 4 * $urandom_range(0, LowDataWords - 1)
                               + $urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [DataW-1:0] data_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 3) return '1;
    return $urandom;
  endfunction

  // mostly register traffic and well-aimed triggers, some noise
  function automatic bus_beat_t random_beat();
    bus_beat_t b;
    int        pick;
    b.action      = ActRead;
    b.offset      = OffsetW'($urandom_range(0, 4095));
    b.write_value = $urandom;
    b.func        = FuncW'($urandom_range(0, FuncSlots - 1));
    b.sub         = SubW'($urandom_range(0, 31));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      b.action      = ActWrite;
      b.offset      = reg_offset();
      b.write_value = data_word();
    end else if (pick < 50) begin
      b.action = ActRead;
      b.offset = reg_offset();
    end else if (pick < 80) begin
      b.action = ActTrigger;
      pick = $urandom_range(0, 9);
      if (pick < 7) b.sub = SubW'($urandom_range(0, int'(TblCount[b.func]) - 1));
      else if (pick == 9) b.sub = SubW'($urandom_range(30, 31));
    end else if (pick < 95) begin
      b.action = $urandom_range(0, 1) ? ActWrite : ActRead;
    end else begin
      b.action = ActSpare;
    end
    return b;
  endfunction

  task automatic push_beat(input logic [ActionW-1:0] act, input int off,
                           input logic [DataW-1:0] wv, input int fn, input int sb);
    bus_beat_t b;
    b.action      = act;
    b.offset      = OffsetW'(off);
    b.write_value = wv;
    b.func        = FuncW'(fn);
    b.sub         = SubW'(sb);
    bus_event_q.push_back(b);
  endtask

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got_v,
                                 input logic [DataW-1:0] want_v);
    if (mismatches < PrintCap)
      $display("mismatch: %s at result %0d: got %h, expected %h",
               what, results_out, got_v, want_v);
    mismatches++;
  endtask

  // sender pause: nothing queued, nothing offered, nothing owed
  task automatic drain_all();
    while (bus_event_q.size() != 0 || in_valid_i || reply_q.size() != 0)
      @(posedge clk_i);
  endtask

  // input driver, next beat once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || beat_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (bus_event_q.size() != 0) begin
          tx_beat = bus_event_q.pop_front();
          action_i      <= tx_beat.action;
          offset_i      <= tx_beat.offset;
          write_value_i <= tx_beat.write_value;
          func_i        <= tx_beat.func;
          sub_i         <= tx_beat.sub;
          in_valid_i    <= 1'b1;
          gap_left = tx_idle ? idle_len() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver with random stalls and one long hold on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_served != hold_ask) begin
        hold_served++;
        hold_left = LongHold - 1;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_left = rx_idle ? idle_len() : 0;
        out_ready_i <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // predict on every input beat, check every result beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        reply_q.push_back(msi_response_of({action_i, offset_i, write_value_i, func_i, sub_i}));
        beats_in++;
        if (action_i == ActTrigger) n_triggers++;
      end
      if (out_valid_o && out_ready_i) begin
        got = {read_data_o, msi_valid_o, msi_address_o, msi_data_o, trigger_error_o};
        if (reply_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", got.read_data, '0);
        end else begin
          want = reply_q.pop_front();
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.msi_valid !== want.msi_valid)
            report_mismatch("msi_valid", DataW'(got.msi_valid), DataW'(want.msi_valid));
          if (got.msi_address !== want.msi_address)
            report_mismatch("msi_address", got.msi_address, want.msi_address);
          if (got.msi_data !== want.msi_data)
            report_mismatch("msi_data", got.msi_data, want.msi_data);
          if (got.trigger_error !== want.trigger_error)
            report_mismatch("trigger_error", DataW'(got.trigger_error),
                            DataW'(want.trigger_error));
          if (want.msi_valid) n_msgs++;
          if (want.trigger_error) n_errs++;
        end
        results_out++;
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no beat moved for %0d cycles", StallLimit);
      $display("tb_msi_vector_register_controller_top: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // unmapped low offsets read zero and ignore writes
    push_beat(ActRead, 'h000, '0, 0, 0);
    push_beat(ActWrite, 'h004, '1, 7, 31);
    push_beat(ActRead, 'h004, '0, 0, 0);
    push_beat(ActRead, 'h008, '1, 0, 0);
    // function 0 fully set up
    push_beat(ActWrite, int'(MaskBase), '1, 0, 0);
    push_beat(ActWrite, int'(DataBase), 32'hA5A5_0000, 0, 0);
    push_beat(ActWrite, int'(AddrBase), 32'hFEE0_0000, 0, 0);
    push_beat(ActWrite, int'(TableBase), 32'h0000_00FF, 0, 0);
    push_beat(ActWrite, int'(TableBase) + 'h00F, 32'h0000_1234, 0, 0);
    push_beat(ActTrigger, 'hFFF, '1, 0, 0);
    push_beat(ActTrigger, 'h000, '0, 0, 3);
    // beyond the count with the mask bit set, then above thirty
    push_beat(ActTrigger, 'h000, '0, 0, 4);
    push_beat(ActTrigger, 'h000, '0, 0, 31);
    // masked triggers, in range and beyond the count
    push_beat(ActTrigger, 'h000, '0, 1, 0);
    push_beat(ActTrigger, 'h000, '0, 1, 20);
    // last function and last table word
    push_beat(ActWrite, int'(MaskBase) + 4 * (FuncCount - 1), 32'h8000_000F, 0, 0);
    push_beat(ActWrite, int'(AddrBase) + 4 * (FuncCount - 1), '1, 0, 0);
    push_beat(ActWrite, int'(TableBase) + 4 * (LowDataWords - 1), '1, 0, 0);
    push_beat(ActRead, int'(TableBase) + 4 * (LowDataWords - 1), '0, 0, 0);
    push_beat(ActTrigger, 'h000, '0, FuncCount - 1, 3);
    // first word past the table, top offset, unused action
    push_beat(ActWrite, int'(TableBase) + 4 * LowDataWords, 32'hDEAD_BEEF, 0, 0);
    push_beat(ActRead, int'(TableBase) + 4 * LowDataWords, '0, 0, 0);
    push_beat(ActRead, 'hFFF, '0, 0, 0);
    push_beat(ActSpare, 'hFFF, '1, 7, 31);
    // widest function at its last subfunction and at the highest legal subfunction
    push_beat(ActWrite, int'(MaskBase) + 16, '1, 0, 0);
    push_beat(ActTrigger, 'h000, '0, 4, 23);
    push_beat(ActTrigger, 'h000, '0, 4, 30);
    drain_all();

    // random traffic with idling on both sides
    repeat (RandChunk) bus_event_q.push_back(random_beat());
    while (bus_event_q.size() != 0) @(posedge clk_i);

    // back to back, no idling anywhere
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (RandChunk) bus_event_q.push_back(random_beat());
    drain_all();

    // receiver holds off while the sender keeps offering
    rx_idle = 1'b1;
    hold_ask++;
    repeat (RandChunk) bus_event_q.push_back(random_beat());
    while (bus_event_q.size() > RandChunk / 2) @(posedge clk_i);
    tx_idle = 1'b1;
    drain_all();
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d beats in, %0d result beats checked, %0d triggers", beats_in, results_out,
             n_triggers);
    $display("%0d messages issued, %0d trigger errors, %0d mismatches", n_msgs, n_errs,
             mismatches);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("tb_msi_vector_register_controller_top: PASS");
    end else begin
      $display("tb_msi_vector_register_controller_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/msivrc_pkg.sv
sv/msi_vector_register_controller_top.sv
sv/msivrc_chk.sv
tb/tb_msi_vector_register_controller_top.sv
